>>> rtl/bcfb_pkg.sv
// Shared types, constants and the glyph lookup for the bar-graph frame builder.
// Depends on nothing; every other file but bcfb_queue uses it.
package bcfb_pkg;

    // Width of one column value, one stored level and one display byte.
    localparam int VALUE_W = 16;
    localparam int LEVEL_W = 5;
    localparam int BYTE_W  = 8;

    // Column index field in the store write word, wide enough for the largest column count.
    localparam int COL_W = 5;

    // Sub-levels per character cell and the fraction bits of the Q2.14 input.
    localparam int CELL_STEPS = 8;
    localparam int FRAC_W     = 14;

    // Display codes.
    localparam logic [BYTE_W-1:0] HOME_BYTE  = 8'h16;
    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
    localparam logic [BYTE_W-1:0] GLYPH_BASE = 8'hF6;

    // One write into the level store, from the front to the back.
    typedef struct packed {
        logic               en;
        logic               bank;
        logic [COL_W-1:0]   col;
        logic [LEVEL_W-1:0] level;
    } level_wr_t;

    // Character for one cell, given its column level and its row counted from the bottom.
    function automatic logic [BYTE_W-1:0] cell_glyph(input logic [LEVEL_W-1:0] level,
                                                     input logic [1:0] row_from_bottom);
        logic [LEVEL_W-1:0] base;
        logic [LEVEL_W-1:0] sub;
        logic [2:0]         sub_c;
        base = {row_from_bottom, 3'b000};
        if (level > base)
            sub = level - base;
        else
            sub = '0;
        if (sub > LEVEL_W'(CELL_STEPS - 1))
            sub_c = 3'(CELL_STEPS - 1);
        else
            sub_c = sub[2:0];
        if (sub_c == 3'd0)
            return SPACE_BYTE;
        else
            return GLYPH_BASE + {5'd0, sub_c} - 8'd1;
    endfunction

endpackage

>>> rtl/bcfb_if.sv
// Stream interfaces for the column words in and the frame bytes out.
// Depends on bcfb_pkg for the payload widths.
interface bcfb_col_if;
    logic                          valid;
    logic                          ready;
    logic [bcfb_pkg::VALUE_W-1:0]  column_value;

    modport source (output valid, output column_value, input ready);
    modport sink   (input valid, input column_value, output ready);
endinterface

interface bcfb_frame_if;
    logic                          valid;
    logic                          ready;
    logic [bcfb_pkg::BYTE_W-1:0]   frame_byte;
    logic                          last_of_frame;

    modport source (output valid, output frame_byte, output last_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input last_of_frame, output ready);
endinterface

>>> rtl/bcfb_front.sv
// Front end: accepts column words, scales them to levels and hands them to the store.
// Depends on bcfb_pkg; feeds bcfb_queue and bcfb_back.
module bcfb_front #(
    parameter int COLUMNS = 20,
    parameter int ROWS    = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [bcfb_pkg::VALUE_W-1:0] in_value,
    output logic                         in_ready,
    output bcfb_pkg::level_wr_t          wr,
    output logic                         push,
    output logic                         push_bank,
    input  logic                         frame_done
);
    import bcfb_pkg::*;

    localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int FULL = ROWS * CELL_STEPS;
    localparam int PW   = VALUE_W + LEVEL_W + 1;

    logic [CW-1:0]      col_reg, col_next;
    logic               bank_reg, bank_next;
    logic [1:0]         busy_reg, busy_next;
    level_wr_t          wr_reg, wr_next;
    logic               push_reg, push_next;
    logic               push_bank_reg, push_bank_next;
    logic               accept;
    logic               last_col;
    logic [PW-1:0]      scaled;
    logic [7:0]         raw_level;
    logic [LEVEL_W-1:0] level;

    // Two banks can be in flight; stop taking words when both hold unsent frames.
    assign in_ready = (busy_reg != 2'd2);
    assign accept   = in_valid && in_ready;
    assign last_col = (col_reg == CW'(COLUMNS - 1));

    // Level is round(FULL * value) with halves up, saturated at FULL.
    always_comb
    begin
        scaled    = PW'(FULL) * PW'(in_value) + PW'(1 << (FRAC_W - 1));
        raw_level = scaled[FRAC_W +: 8];
        if (raw_level > 8'(FULL))
            level = LEVEL_W'(FULL);
        else
            level = raw_level[LEVEL_W-1:0];
    end

    // Column position, bank choice and the count of frames not yet fully sent.
    always_comb
    begin
        col_next       = col_reg;
        bank_next      = bank_reg;
        push_next      = 1'b0;
        push_bank_next = bank_reg;
        wr_next        = wr_reg;
        wr_next.en     = 1'b0;
        if (accept)
        begin
            wr_next.en    = 1'b1;
            wr_next.bank  = bank_reg;
            wr_next.col   = COL_W'(col_reg);
            wr_next.level = level;
            if (last_col)
            begin
                col_next  = '0;
                bank_next = ~bank_reg;
                push_next = 1'b1;
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        busy_next = busy_reg + {1'b0, push_next} - {1'b0, frame_done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
            push_reg <= 1'b0;
            wr_reg   <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
            push_reg <= push_next;
            wr_reg   <= wr_next;
        end
    end

    // The bank tag of the queued frame needs no reset.
    always_ff @(posedge clk)
    begin
        push_bank_reg <= push_bank_next;
    end

    assign wr        = wr_reg;
    assign push      = push_reg;
    assign push_bank = push_bank_reg;

endmodule

>>> rtl/bcfb_queue.sv
// Two-entry queue of finished frames, each tagged with the store bank that holds it.
// Depends on nothing; sits between bcfb_front and bcfb_back.
module bcfb_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic push_bank,
    input  logic pop,
    output logic head_valid,
    output logic head_bank
);
    logic [1:0] slot_reg;
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign head_valid = (count_reg != 2'd0);
    assign head_bank  = slot_reg[rptr_reg];

    // Pointers and fill count; the front never pushes into a full queue.
    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ (pop && head_valid);
        count_next = count_reg + {1'b0, push} - {1'b0, pop && head_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_bank;
    end

endmodule

>>> rtl/bcfb_back.sv
// Back end: holds the two-bank level store and streams each frame out one byte a cycle while out_ready allows.
// Depends on bcfb_pkg; takes frames from bcfb_queue and store writes from bcfb_front.
module bcfb_back #(
    parameter int COLUMNS = 20,
    parameter int ROWS    = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bcfb_pkg::level_wr_t         wr,
    input  logic                        head_valid,
    input  logic                        head_bank,
    output logic                        pop,
    output logic                        frame_done,
    output logic                        out_valid,
    output logic [bcfb_pkg::BYTE_W-1:0] out_byte,
    output logic                        out_last,
    input  logic                        out_ready
);
    import bcfb_pkg::*;

    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int DEPTH = 2 * (2 ** CW);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_HOME  = 3'b010,
        ST_CELLS = 3'b100
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    logic               bank_reg, bank_next;
    logic [1:0]         row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_home_reg, s1_home_next;
    logic [1:0]         s1_row_reg, s1_row_next;
    logic               s1_last_reg, s1_last_next;
    logic [LEVEL_W-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;
    logic               advance;
    logic               last_cell;
    logic [LEVEL_W-1:0] mem [DEPTH];

    // The read stage and the output word move together whenever the output is free.
    assign advance   = !out_valid_reg || out_ready;
    assign last_cell = (row_reg == 2'd0) && (col_reg == CW'(COLUMNS - 1));

    // Sequencer: home byte, then rows from the top, columns left to right.
    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        s1_valid_next = s1_valid_reg;
        s1_home_next  = s1_home_reg;
        s1_row_next   = s1_row_reg;
        s1_last_next  = s1_last_reg;
        pop           = 1'b0;
        frame_done    = 1'b0;
        if (advance)
            s1_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    bank_next  = head_bank;
                    state_next = ST_HOME;
                end
            end
            ST_HOME:
            begin
                if (advance)
                begin
                    s1_valid_next = 1'b1;
                    s1_home_next  = 1'b1;
                    s1_last_next  = 1'b0;
                    row_next      = 2'(ROWS - 1);
                    col_next      = '0;
                    state_next    = ST_CELLS;
                end
            end
            ST_CELLS:
            begin
                if (advance)
                begin
                    s1_valid_next = 1'b1;
                    s1_home_next  = 1'b0;
                    s1_row_next   = row_reg;
                    s1_last_next  = last_cell;
                    if (col_reg == CW'(COLUMNS - 1))
                    begin
                        col_next = '0;
                        if (row_reg == 2'd0)
                        begin
                            frame_done = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            row_next = row_reg - 2'd1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= s1_valid_next;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Sequencer counters and stage payload.
    always_ff @(posedge clk)
    begin
        bank_reg    <= bank_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        s1_home_reg <= s1_home_next;
        s1_row_reg  <= s1_row_next;
        s1_last_reg <= s1_last_next;
        if (advance)
        begin
            out_byte_reg <= s1_home_reg ? HOME_BYTE : cell_glyph(rd_data_reg, s1_row_reg);
            out_last_reg <= s1_last_reg;
        end
    end

    // Level store: the front fills one bank while the other one is read out.
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[{wr.bank, wr.col[CW-1:0]}] <= wr.level;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rd_data_reg <= mem[{bank_reg, col_reg}];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

>>> rtl/bargraph_character_frame_builder.sv
// Top level of the bar-graph character frame builder.
// Depends on bcfb_pkg, bcfb_if, bcfb_front, bcfb_queue and bcfb_back.
//
//   Channel   Dir   Word                          Accepted when
//   columns   in    column_value (Q2.14)          columns.valid && columns.ready
//   frame     out   frame_byte, last_of_frame     frame.valid && frame.ready
//
// A column word is taken in any cycle with columns.ready high. After the last column of a frame
// the back end sends ROWS*COLUMNS+1 bytes, one a cycle while frame.ready holds; the home
// byte passes the push register, the queue, the home state, the read stage and the output
// register. The store has two banks, so the next frame's columns are taken while one frame
// is sent; columns stall only while two finished frames are not yet fully sent, and the
// output register paces the bytes, with a bubble in the idle state between frames.
// Reset clears the column count, bank choice, queue and sequencer; the store is not cleared.
module bargraph_character_frame_builder #(
    parameter int COLUMNS = 20,
    parameter int ROWS    = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    bcfb_col_if.sink           columns,
    bcfb_frame_if.source       frame
);
    import bcfb_pkg::*;

    level_wr_t wr;
    logic      push;
    logic      push_bank;
    logic      pop;
    logic      head_valid;
    logic      head_bank;
    logic      frame_done;

    // Front end: scale words to levels and announce finished frames.
    bcfb_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (columns.valid),
        .in_value   (columns.column_value),
        .in_ready   (columns.ready),
        .wr         (wr),
        .push       (push),
        .push_bank  (push_bank),
        .frame_done (frame_done)
    );

    // Queue of frames waiting for the back end.
    bcfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_bank  (push_bank),
        .pop        (pop),
        .head_valid (head_valid),
        .head_bank  (head_bank)
    );

    // Back end: store and byte sequencer.
    bcfb_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .head_valid (head_valid),
        .head_bank  (head_bank),
        .pop        (pop),
        .frame_done (frame_done),
        .out_valid  (frame.valid),
        .out_byte   (frame.frame_byte),
        .out_last   (frame.last_of_frame),
        .out_ready  (frame.ready)
    );

endmodule
